FILE: sv/fda_pkg.sv
// Package for the fractional-delay allpass block: sizes, codes, control word
// layout and the sequencer's microcode table.
// No dependencies.
package fda_pkg;

   // Sizes
   localparam int LINE_DEPTH      = 4096;
   localparam int DELAY_FRAC_BITS = 8;
   localparam int ADDR_W          = $clog2(LINE_DEPTH);
   localparam int POS_W           = ADDR_W + DELAY_FRAC_BITS;
   localparam int FRAC_W          = (DELAY_FRAC_BITS > 0) ? DELAY_FRAC_BITS : 1;
   localparam int SMP_W           = 24;
   localparam int DLEN_W          = 20;
   localparam int GAIN_W          = 16;
   localparam int CSR_IDX_W       = 8;
   localparam int CSR_DATA_W      = 20;
   localparam int CMP_W           = ((DLEN_W > POS_W) ? DLEN_W : POS_W) + 1;
   localparam int MA_W            = SMP_W + 1;
   localparam int MB_W            = ((GAIN_W > FRAC_W) ? GAIN_W : FRAC_W) + 1;
   localparam int PROD_W          = MA_W + MB_W;
   localparam int SUM_W           = SMP_W + 4;
   localparam int GAIN_SHIFT      = GAIN_W - 1;

   // Constants
   localparam longint DMIN      = 64'sd1 << DELAY_FRAC_BITS;
   localparam longint DMAX      = longint'(LINE_DEPTH - 1) << DELAY_FRAC_BITS;
   localparam longint HALF_FRAC = (DELAY_FRAC_BITS > 0) ?
                                  (64'sd1 << (DELAY_FRAC_BITS - 1)) : 64'sd0;
   localparam longint HALF_GAIN = 64'sd1 << (GAIN_SHIFT - 1);
   localparam longint SMP_MAX   = (64'sd1 << (SMP_W - 1)) - 1;
   localparam longint SMP_MIN   = -(64'sd1 << (SMP_W - 1));
   localparam logic signed [GAIN_W-1:0] GAIN_LIMIT = 16'sd32751;
   localparam logic [DLEN_W-1:0] DLEN_RESET = 20'd256;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DELAY_LENGTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK_GAIN = 8'd1;

   // Control word fields
   typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_REQ, SEQ_WAIT_OUT, SEQ_RETURN} seq_type;
   typedef enum logic [1:0] {RD_NONE, RD_TAP_A, RD_TAP_B} rd_sel_type;
   typedef enum logic [1:0] {MA_DIFF, MA_X, MA_Y} mula_type;
   typedef enum logic [1:0] {MB_FRAC, MB_GAIN, MB_NEG_GAIN} mulb_type;
   typedef enum logic [1:0] {AB_A, AB_DL, AB_X} acc_base_type;
   typedef enum logic {SH_FRAC, SH_GAIN} acc_sh_type;
   typedef enum logic [1:0] {AD_NONE, AD_DL, AD_Y, AD_W} acc_dst_type;

   typedef struct packed {
      seq_type      seq;
      logic         lat_in;
      rd_sel_type   rd_sel;
      logic         lat_a;
      logic         lat_b;
      logic         mul_en;
      mula_type     mul_a;
      mulb_type     mul_b;
      acc_base_type acc_base;
      acc_sh_type   acc_sh;
      acc_dst_type  acc_dst;
   } cw_type;

   typedef struct packed {
      cw_type cw;
      logic   go;
   } ctrl_type;

   typedef struct packed {
      logic [DLEN_W-1:0]        delay_length;
      logic signed [GAIN_W-1:0] feedback_gain;
   } cfg_type;

   localparam int UC_STEPS = 8;
   localparam int STEP_W   = $clog2(UC_STEPS);

   // Microcode: one word per step
   localparam cw_type UCODE [UC_STEPS] = '{
      // take sample, read tap A
      '{seq: SEQ_WAIT_REQ, lat_in: 1'b1, rd_sel: RD_TAP_A, lat_a: 1'b0, lat_b: 1'b0,
        mul_en: 1'b0, mul_a: MA_DIFF, mul_b: MB_FRAC, acc_base: AB_A, acc_sh: SH_FRAC,
        acc_dst: AD_NONE},
      // latch A, read tap B
      '{seq: SEQ_NEXT, lat_in: 1'b0, rd_sel: RD_TAP_B, lat_a: 1'b1, lat_b: 1'b0,
        mul_en: 1'b0, mul_a: MA_DIFF, mul_b: MB_FRAC, acc_base: AB_A, acc_sh: SH_FRAC,
        acc_dst: AD_NONE},
      // latch B
      '{seq: SEQ_NEXT, lat_in: 1'b0, rd_sel: RD_NONE, lat_a: 1'b0, lat_b: 1'b1,
        mul_en: 1'b0, mul_a: MA_DIFF, mul_b: MB_FRAC, acc_base: AB_A, acc_sh: SH_FRAC,
        acc_dst: AD_NONE},
      // (B - A) * frac
      '{seq: SEQ_NEXT, lat_in: 1'b0, rd_sel: RD_NONE, lat_a: 1'b0, lat_b: 1'b0,
        mul_en: 1'b1, mul_a: MA_DIFF, mul_b: MB_FRAC, acc_base: AB_A, acc_sh: SH_FRAC,
        acc_dst: AD_NONE},
      // D = A + round(prod); x * -g
      '{seq: SEQ_NEXT, lat_in: 1'b0, rd_sel: RD_NONE, lat_a: 1'b0, lat_b: 1'b0,
        mul_en: 1'b1, mul_a: MA_X, mul_b: MB_NEG_GAIN, acc_base: AB_A, acc_sh: SH_FRAC,
        acc_dst: AD_DL},
      // y = sat(D + round(prod)), wait for output register
      '{seq: SEQ_WAIT_OUT, lat_in: 1'b0, rd_sel: RD_NONE, lat_a: 1'b0, lat_b: 1'b0,
        mul_en: 1'b0, mul_a: MA_X, mul_b: MB_GAIN, acc_base: AB_DL, acc_sh: SH_GAIN,
        acc_dst: AD_Y},
      // g * y
      '{seq: SEQ_NEXT, lat_in: 1'b0, rd_sel: RD_NONE, lat_a: 1'b0, lat_b: 1'b0,
        mul_en: 1'b1, mul_a: MA_Y, mul_b: MB_GAIN, acc_base: AB_X, acc_sh: SH_GAIN,
        acc_dst: AD_NONE},
      // w = sat(x + round(prod)) into the line, advance pointer
      '{seq: SEQ_RETURN, lat_in: 1'b0, rd_sel: RD_NONE, lat_a: 1'b0, lat_b: 1'b0,
        mul_en: 1'b0, mul_a: MA_Y, mul_b: MB_GAIN, acc_base: AB_X, acc_sh: SH_GAIN,
        acc_dst: AD_W}
   };

endpackage

FILE: sv/fda_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fda_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fda_sequencer.sv
// Microcode sequencer: step counter, control word lookup and jumps.
// Depends on fda_pkg.
module fda_sequencer
   import fda_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     out_busy,
   output ctrl_type ctrl,
   output logic     req_stall
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   cw_type            cw;
   logic              go;

   // Control word fetch and jump condition
   always_comb begin
      cw = UCODE[step_ff];
      case (cw.seq)
         SEQ_WAIT_REQ: go = req_valid;
         SEQ_WAIT_OUT: go = !out_busy;
         default:      go = 1'b1;
      endcase
      if (!go) begin
         step_in = step_ff;
      end else if (cw.seq == SEQ_RETURN) begin
         step_in = '0;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.cw   = cw;
   assign ctrl.go   = go;
   assign req_stall = (cw.seq != SEQ_WAIT_REQ);

endmodule

FILE: sv/fda_datapath.sv
// Datapath: read address generation, delay line RAM, shared multiplier,
// round/saturate adder, write pointer and output register.
// Depends on fda_pkg and fda_ram.
module fda_datapath
   import fda_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_type                ctrl,
   input  cfg_type                 cfg,
   input  logic signed [SMP_W-1:0] req_sample_in,
   input  logic                    rsp_stall,
   output logic                    out_busy,
   output logic                    rsp_valid,
   output logic signed [SMP_W-1:0] rsp_sample_out
);

   // Pointer state
   logic [ADDR_W-1:0] wp_ff;
   logic              wrapped_ff;
   logic              rsp_valid_ff;

   // Per-item payload
   logic signed [SMP_W-1:0]  x_ff;
   logic signed [GAIN_W-1:0] g_ff;
   logic [FRAC_W-1:0]        frac_ff;
   logic [ADDR_W-1:0]        ib_ff;
   logic signed [SMP_W-1:0]  a_ff;
   logic signed [SMP_W-1:0]  b_ff;
   logic signed [SMP_W-1:0]  dl_ff;
   logic signed [SMP_W-1:0]  y_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     rd_ok_ff;

   // Combinational
   logic [CMP_W-1:0]         d_cmp;
   logic [POS_W:0]           d_clamp;
   logic [POS_W:0]           pos_diff;
   logic [POS_W-1:0]         pos;
   logic [ADDR_W-1:0]        ia_c;
   logic [ADDR_W-1:0]        ib_c;
   logic [FRAC_W-1:0]        frac_c;
   logic signed [GAIN_W-1:0] g_c;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [SMP_W-1:0]         rd_data;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_c;
   logic signed [PROD_W-1:0] rnd_frac;
   logic signed [PROD_W-1:0] rnd_gain;
   logic signed [SUM_W-1:0]  base;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SMP_W-1:0]  res;
   logic                     wr_en;
   logic                     act;

   assign act = ctrl.go;

   // Clamp delay and gain, form read position behind the write pointer
   always_comb begin
      d_cmp = CMP_W'(cfg.delay_length);
      if (d_cmp < CMP_W'(DMIN)) begin
         d_clamp = (POS_W + 1)'(DMIN);
      end else if (d_cmp > CMP_W'(DMAX)) begin
         d_clamp = (POS_W + 1)'(DMAX);
      end else begin
         d_clamp = (POS_W + 1)'(cfg.delay_length);
      end
      pos_diff = ((POS_W + 1)'(wp_ff) << DELAY_FRAC_BITS) - d_clamp;
      if (pos_diff[POS_W]) begin
         pos_diff = pos_diff + ((POS_W + 1)'(LINE_DEPTH) << DELAY_FRAC_BITS);
      end
      pos  = pos_diff[POS_W-1:0];
      ia_c = pos[POS_W-1:DELAY_FRAC_BITS];
      ib_c = (ia_c == ADDR_W'(LINE_DEPTH - 1)) ? '0 : ia_c + 1'b1;
      frac_c = (DELAY_FRAC_BITS > 0) ? pos[FRAC_W-1:0] : '0;

      g_c = cfg.feedback_gain;
      if (g_c > GAIN_LIMIT) begin
         g_c = GAIN_LIMIT;
      end else if (g_c < -GAIN_LIMIT) begin
         g_c = -GAIN_LIMIT;
      end
   end

   // RAM port control
   assign rd_en   = act && (ctrl.cw.rd_sel != RD_NONE);
   assign rd_addr = (ctrl.cw.rd_sel == RD_TAP_A) ? ia_c : ib_ff;
   assign wr_en   = act && (ctrl.cw.acc_dst == AD_W);

   fda_ram #(
      .WIDTH(SMP_W),
      .DEPTH(LINE_DEPTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wp_ff),
      .wr_data(res),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Multiplier operand select
   always_comb begin
      case (ctrl.cw.mul_a)
         MA_DIFF: mul_a = MA_W'(b_ff) - MA_W'(a_ff);
         MA_X:    mul_a = MA_W'(x_ff);
         MA_Y:    mul_a = MA_W'(y_ff);
         default: mul_a = '0;
      endcase
      case (ctrl.cw.mul_b)
         MB_FRAC:     mul_b = MB_W'(frac_ff);
         MB_GAIN:     mul_b = MB_W'(g_ff);
         MB_NEG_GAIN: mul_b = -MB_W'(g_ff);
         default:     mul_b = '0;
      endcase
   end

   assign prod_c = mul_a * mul_b;

   // Round half up, add base, saturate
   always_comb begin
      rnd_frac = (prod_ff + PROD_W'(HALF_FRAC)) >>> DELAY_FRAC_BITS;
      rnd_gain = (prod_ff + PROD_W'(HALF_GAIN)) >>> GAIN_SHIFT;
      case (ctrl.cw.acc_base)
         AB_A:    base = SUM_W'(a_ff);
         AB_DL:   base = SUM_W'(dl_ff);
         AB_X:    base = SUM_W'(x_ff);
         default: base = '0;
      endcase
      if (ctrl.cw.acc_sh == SH_FRAC) begin
         sum = base + SUM_W'(rnd_frac);
      end else begin
         sum = base + SUM_W'(rnd_gain);
      end
      if (sum > SUM_W'(SMP_MAX)) begin
         res = SMP_W'(SMP_MAX);
      end else if (sum < SUM_W'(SMP_MIN)) begin
         res = SMP_W'(SMP_MIN);
      end else begin
         res = SMP_W'(sum);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (act && ctrl.cw.lat_in) begin
         x_ff    <= req_sample_in;
         g_ff    <= g_c;
         frac_ff <= frac_c;
         ib_ff   <= ib_c;
      end
      // entries past the fill point read as zero
      if (rd_en) begin
         rd_ok_ff <= wrapped_ff || (rd_addr < wp_ff);
      end
      if (act && ctrl.cw.lat_a) begin
         a_ff <= rd_ok_ff ? rd_data : '0;
      end
      if (act && ctrl.cw.lat_b) begin
         b_ff <= rd_ok_ff ? rd_data : '0;
      end
      if (act && ctrl.cw.mul_en) begin
         prod_ff <= prod_c;
      end
      if (act && (ctrl.cw.acc_dst == AD_DL)) begin
         dl_ff <= res;
      end
      if (act && (ctrl.cw.acc_dst == AD_Y)) begin
         y_ff <= res;
      end
   end

   // Write pointer, fill flag and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            if (wp_ff == ADDR_W'(LINE_DEPTH - 1)) begin
               wp_ff      <= '0;
               wrapped_ff <= 1'b1;
            end else begin
               wp_ff <= wp_ff + 1'b1;
            end
         end
         if (act && (ctrl.cw.acc_dst == AD_Y)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_busy       = rsp_valid_ff && rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = y_ff;

endmodule

FILE: sv/fractional_delay_allpass.sv
// Fractional-delay allpass filter, top level: register file, sequencer
// and datapath. Depends on fda_pkg, fda_sequencer and fda_datapath.
//
// Usage:
// - req_ channel carries one signed Q1.23 sample per transaction, taken at a
//   clock edge with req_valid high and req_stall low.
// - rsp_ channel returns one saturated Q1.23 sample per input, in order,
//   held in an output register until rsp_valid is seen with rsp_stall low.
// - csr_ writes: index 0 is delay_length (8 fraction bits, clamped at use
//   to 1..4095 samples), index 1 is feedback_gain (Q1.15, clamped at use).
//   Other indexes are ignored; csr_ready is always high.
// - rsp_valid rises when the step that forms y runs, after both tap reads,
//   the interpolation and the x * -g product. One sample per pass of the
//   microcode program (req_stall is high outside its first step): two
//   RAM reads on one read port and three passes through the shared multiplier.
// - If the output register is still held by rsp_stall when the next result
//   is ready, the sequencer waits on that step and req_stall stays high.
// - Reset (synchronous) empties the delay line at once: entries not yet
//   written since reset read as zero, tracked by the write pointer and a
//   wrap flag, so no clearing pass is needed.
module fractional_delay_allpass
   import fda_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [SMP_W-1:0] req_sample_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SMP_W-1:0] rsp_sample_out,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [DLEN_W-1:0]        dlen_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   cfg_type                  cfg;
   ctrl_type                 ctrl;
   logic                     out_busy;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dlen_ff <= DLEN_RESET;
         gain_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DELAY_LENGTH:  dlen_ff <= csr_wdata[DLEN_W-1:0];
            REG_FEEDBACK_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready         = 1'b1;
   assign cfg.delay_length  = dlen_ff;
   assign cfg.feedback_gain = gain_ff;

   fda_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .out_busy (out_busy),
      .ctrl     (ctrl),
      .req_stall(req_stall)
   );

   fda_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .cfg           (cfg),
      .req_sample_in (req_sample_in),
      .rsp_stall     (rsp_stall),
      .out_busy      (out_busy),
      .rsp_valid     (rsp_valid),
      .rsp_sample_out(rsp_sample_out)
   );

endmodule

FILE: bench/fractional_delay_allpass_tb.sv
`timescale 1ns / 100ps
// Testbench for fractional_delay_allpass: directed and random samples, checked
// against a cycle-free allpass predictor. Depends on fda_pkg and the RTL.
module fractional_delay_allpass_tb;
   import fda_pkg::*;

   localparam int     SETTLE_CYCLES = 12;
   localparam longint FRAC_ONE      = 64'sd1 << DELAY_FRAC_BITS;
   localparam longint Q15_HALF      = 64'sd1 << 14;
   localparam logic signed [SMP_W-1:0] X_MAX = SMP_MAX[SMP_W-1:0];
   localparam logic signed [SMP_W-1:0] X_MIN = SMP_MIN[SMP_W-1:0];

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [SMP_W-1:0] req_sample_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SMP_W-1:0] rsp_sample_out;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Predictor state: line contents, pointer and register copies
   logic signed [SMP_W-1:0]  line_mem [LINE_DEPTH];
   int                       wr_ptr;
   logic [DLEN_W-1:0]        delay_reg;
   logic signed [GAIN_W-1:0] gain_reg;

   logic signed [SMP_W-1:0] allpass_out_q [$];
   int                      fail_count = 0;
   bit                      offering = 1'b0;
   bit                      req_idle_on = 1'b0;
   bit                      rsp_idle_on = 1'b0;
   int                      hold_cycles = 0;
   int                      stall_left = 0;

   fractional_delay_allpass DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint clip_q23(input longint v);
      if (v > SMP_MAX) return SMP_MAX;
      if (v < SMP_MIN) return SMP_MIN;
      return v;
   endfunction

   // One sample through the allpass: interpolated tap, output, line update
   function automatic logic signed [SMP_W-1:0] allpass_predict(
      input logic signed [SMP_W-1:0] x);
      longint xs, g, d, pos, frac, tap_a, tap_b, dl, yv, wv;
      int     ia, ib;
      xs = x;
      g  = gain_reg;
      d  = longint'(delay_reg);
      if (d < DMIN) d = DMIN;
      if (d > DMAX) d = DMAX;
      if (g > longint'(GAIN_LIMIT)) g = longint'(GAIN_LIMIT);
      if (g < -longint'(GAIN_LIMIT)) g = -longint'(GAIN_LIMIT);
      // read position behind the pointer, wrapped when negative
      pos = longint'(wr_ptr) * FRAC_ONE - d;
      if (pos < 0) pos += longint'(LINE_DEPTH) * FRAC_ONE;
      ia    = int'(pos >>> DELAY_FRAC_BITS) % LINE_DEPTH;
      ib    = (ia + 1) % LINE_DEPTH;
      frac  = pos & (FRAC_ONE - 1);
      tap_a = line_mem[ia];
      tap_b = line_mem[ib];
      dl = (tap_a * (FRAC_ONE - frac) + tap_b * frac + HALF_FRAC) >>> DELAY_FRAC_BITS;
      yv = clip_q23((dl * 32768 - g * xs + Q15_HALF) >>> 15);
      wv = clip_q23((xs * 32768 + g * yv + Q15_HALF) >>> 15);
      line_mem[wr_ptr] = wv[SMP_W-1:0];
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      return yv[SMP_W-1:0];
   endfunction

   // Idle length: mostly none, sometimes short, rarely long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SMP_W-1:0] rand_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return X_MAX;
         1: return X_MIN;
         2, 3: return SMP_W'($signed($urandom_range(0, 512)) - 256);
         default: return r[SMP_W-1:0];
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_delay();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 7))
         0: return CSR_DATA_W'($urandom_range(0, 255));
         1: return CSR_DATA_W'($urandom_range(1048320, 1048575));
         2: return r[CSR_DATA_W-1:0];
         3: return CSR_DATA_W'($urandom_range(256, 4095 * 256));
         default: return CSR_DATA_W'($urandom_range(256, 24 * 256));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_gain();
      logic [31:0] r;
      logic [3:0]  pad;
      r   = $urandom();
      pad = r[19:16];
      case ($urandom_range(0, 5))
         0: return {pad, 16'h7FFF};
         1: return {pad, 16'h8000};
         2: return {pad, (($urandom_range(0, 1) != 0) ? 16'sd32751 : -16'sd32751)};
         3: return {pad, 16'($signed($urandom_range(0, 64)) - 32)};
         default: return r[CSR_DATA_W-1:0];
      endcase
   endfunction

   // Result side: check each transaction, then drive stall for the next edge
   task automatic check_sample_out(input logic signed [SMP_W-1:0] actual);
      logic signed [SMP_W-1:0] want;
      if (allpass_out_q.size() == 0) begin
         $error("sample_out: unexpected result, actual %0d", actual);
         fail_count++;
      end else begin
         want = allpass_out_q.pop_front();
         if (actual !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, actual);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) check_sample_out(rsp_sample_out);
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 35) begin
         rsp_stall  <= 1'b1;
         stall_left = pick_idle();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one sample after gap idle cycles; valid stays high for a follow-on
   task automatic send_sample(input logic signed [SMP_W-1:0] x, input int gap);
      if (offering && gap > 0) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      if (!offering) repeat ((gap > 0) ? gap : 1) @(posedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= x;
      offering = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      allpass_out_q.push_back(allpass_predict(x));
   endtask

   task automatic stop_offer();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // All results back, then room for the line write-back to finish
   task automatic wait_idle();
      while (allpass_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      stop_offer();
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_DELAY_LENGTH) delay_reg = data[DLEN_W-1:0];
      else if (idx == REG_FEEDBACK_GAIN) gain_reg = data[GAIN_W-1:0];
   endtask

   // Reset values: one-sample delay, zero gain, so y is the previous x
   task automatic test_reset_defaults();
      send_sample(X_MAX, 0);
      send_sample(X_MIN, 0);
      send_sample('0, 1);
      send_sample(24'sd1, 0);
      send_sample(-24'sd1, 2);
      send_sample(X_MAX, 0);
   endtask

   // Clamping of both registers, saturation, fraction and ignored indexes
   task automatic test_register_extremes();
      int i;
      csr_write(REG_FEEDBACK_GAIN, 20'hF7FFF);
      csr_write(REG_DELAY_LENGTH, '0);
      for (i = 0; i < 4; i++) send_sample(X_MAX, 0);
      csr_write(REG_FEEDBACK_GAIN, 20'h08000);
      for (i = 0; i < 3; i++) send_sample(X_MAX, 0);
      for (i = 0; i < 3; i++) send_sample(X_MIN, 0);
      csr_write(REG_DELAY_LENGTH, 20'hFFFFF);
      csr_write(REG_FEEDBACK_GAIN, 20'h07FEF);
      send_sample(X_MAX, 0);
      send_sample(X_MIN, 0);
      // 1.5 samples back, small negative gain
      csr_write(REG_DELAY_LENGTH, 20'h00180);
      csr_write(REG_FEEDBACK_GAIN, 20'h0FFFF);
      send_sample(24'sd1000001, 0);
      send_sample(-24'sd77777, 0);
      send_sample(24'sd3, 0);
      // writes to unknown indexes leave both registers alone
      csr_write(8'd2, CSR_DATA_W'($urandom()));
      csr_write(8'hFF, CSR_DATA_W'($urandom()));
      send_sample(X_MIN, 0);
      send_sample(24'sd12345, 0);
   endtask

   // Random settings, each followed by a run of random samples
   task automatic test_random_phases();
      int ph, i;
      for (ph = 0; ph < 9; ph++) begin
         csr_write(REG_DELAY_LENGTH, rand_delay());
         csr_write(REG_FEEDBACK_GAIN, rand_gain());
         req_idle_on = (ph % 4) != 3;
         rsp_idle_on = (ph % 4) != 2;
         for (i = 0; i < 150; i++) send_sample(rand_sample(), req_idle_on ? pick_idle() : 0);
      end
   endtask

   // Receiver holds off so the block fills up, then the sender pauses
   task automatic test_output_backpressure();
      int i;
      csr_write(REG_DELAY_LENGTH, 20'h00340);
      csr_write(REG_FEEDBACK_GAIN, 20'h04000);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_cycles = 400;
      for (i = 0; i < 16; i++) send_sample(rand_sample(), 0);
      stop_offer();
      while (allpass_out_q.size() != 0) @(posedge clock);
      for (i = 0; i < 40; i++) send_sample(rand_sample(), 0);
   endtask

   initial begin
      for (int k = 0; k < LINE_DEPTH; k++) line_mem[k] = '0;
      wr_ptr    = 0;
      delay_reg = DLEN_RESET;
      gain_reg  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_phases();
      test_output_backpressure();
      stop_offer();
      wait_idle();
      if (fail_count == 0 && allpass_out_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Run limit
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
